// ===== hdl/adi_pkg.sv =====
// Shared constants, codes and command/status types of the ADI heat step core.
package adi_pkg;

  localparam int GRID_I = 64;
  localparam int GRID_J = 64;
  localparam int CELLS  = GRID_I * GRID_J;
  localparam int IW     = $clog2(GRID_I);
  localparam int JW     = $clog2(GRID_J);
  localparam int PW     = (IW > JW) ? IW : JW;
  localparam int CELL_W = $clog2(CELLS);

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int WIDE_W = 50;
  localparam int PROD_W = 64;
  localparam int IDX_W  = 6;
  localparam int MODE_W = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFDIAG   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_DIAG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFDIAG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_DIAG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WEIGHT = 3'd4;

  localparam logic [DATA_W-1:0] RST_OFFDIAG = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RST_DIAG    = 32'h0003_0000;
  localparam logic [DATA_W-1:0] RST_TWEIGHT = 32'h0001_0000;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_WRCELL,
    DP_RES_ZERO,
    DP_RDCAP,
    DP_STEP_START,
    DP_MUL_A,
    DP_MUL_B,
    DP_MUL_C,
    DP_DIV_GO,
    DP_FWD_WR,
    DP_BK_MUL,
    DP_BK_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [CELL_W-1:0]   addr;
    logic                sweep;
    logic                solved;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mask;
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== hdl/adi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module adi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/adi_div.sv =====
// Two-lane radix-2 Q16.16 divider sharing one divisor, with saturation.
module adi_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [adi_pkg::WIDE_W-1:0] num_a,
  input  logic signed [adi_pkg::WIDE_W-1:0] num_b,
  input  logic signed [adi_pkg::WIDE_W-1:0] den,
  output logic                              busy,
  output logic [adi_pkg::DATA_W-1:0]        quo_a,
  output logic [adi_pkg::DATA_W-1:0]        quo_b,
  output logic                              sat
);
  import adi_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic signed [WIDE_W-1:0] num [2];
  logic [WIDE_W-1:0]        un [2];
  logic [WIDE_W-1:0]        ud;
  logic [WIDE_W-1:0]        ud_r, ud_nxt;
  logic [WIDE_W:0]          rem_r [2];
  logic [WIDE_W:0]          rem_nxt [2];
  logic [WIDE_W:0]          trial [2];
  logic [DATA_W-1:0]        low_r [2];
  logic [DATA_W-1:0]        low_nxt [2];
  logic [DATA_W-1:0]        q_r [2];
  logic [DATA_W-1:0]        q_nxt [2];
  logic [DATA_W-1:0]        sval_r [2];
  logic [DATA_W-1:0]        sval_nxt [2];
  logic [DATA_W-1:0]        res [2];
  logic                     neg_r [2];
  logic                     neg_nxt [2];
  logic                     spec_r [2];
  logic                     spec_nxt [2];
  logic [1:0]               rsat;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;

  always_comb begin
    num[0] = num_a;
    num[1] = num_b;
    ud = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
    ud_nxt = ud_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    for (int k = 0; k < 2; k++) begin
      un[k] = num[k][WIDE_W-1] ? WIDE_W'(-num[k]) : WIDE_W'(num[k]);
      trial[k] = {rem_r[k][WIDE_W-1:0], low_r[k][DATA_W-1]};
      rem_nxt[k] = rem_r[k];
      low_nxt[k] = low_r[k];
      q_nxt[k] = q_r[k];
      neg_nxt[k] = neg_r[k];
      spec_nxt[k] = spec_r[k];
      sval_nxt[k] = sval_r[k];
    end
    if (start) begin
      ud_nxt = ud;
      busy_nxt = 1'b1;
      cnt_nxt = CNT_W'(DATA_W);
      for (int k = 0; k < 2; k++) begin
        neg_nxt[k] = num[k][WIDE_W-1] ^ den[WIDE_W-1];
        rem_nxt[k] = (WIDE_W + 1)'(un[k] >> FRAC_W);
        low_nxt[k] = {un[k][FRAC_W-1:0], {FRAC_W{1'b0}}};
        q_nxt[k] = '0;
        if (ud == '0) begin
          // zero divisor: largest value of the numerator's sign, zero for a zero numerator
          spec_nxt[k] = 1'b1;
          if (num[k][WIDE_W-1]) begin
            sval_nxt[k] = Q_MIN;
          end else if (num[k] != '0) begin
            sval_nxt[k] = Q_MAX;
          end else begin
            sval_nxt[k] = '0;
          end
        end else if ({{FRAC_W{1'b0}}, un[k]} >= {ud, {FRAC_W{1'b0}}}) begin
          // quotient needs more than 32 bits
          spec_nxt[k] = 1'b1;
          sval_nxt[k] = neg_nxt[k] ? Q_MIN : Q_MAX;
        end else begin
          spec_nxt[k] = 1'b0;
          sval_nxt[k] = '0;
        end
      end
    end else if (busy_r) begin
      for (int k = 0; k < 2; k++) begin
        if (trial[k] >= {1'b0, ud_r}) begin
          rem_nxt[k] = trial[k] - {1'b0, ud_r};
          q_nxt[k] = {q_r[k][DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt[k] = trial[k];
          q_nxt[k] = {q_r[k][DATA_W-2:0], 1'b0};
        end
        low_nxt[k] = {low_r[k][DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (spec_r[k]) begin
        res[k] = sval_r[k];
        rsat[k] = 1'b1;
      end else if (!neg_r[k]) begin
        res[k] = q_r[k][DATA_W-1] ? Q_MAX : q_r[k];
        rsat[k] = q_r[k][DATA_W-1];
      end else if (q_r[k] > Q_MIN) begin
        res[k] = Q_MIN;
        rsat[k] = 1'b1;
      end else begin
        res[k] = -q_r[k];
        rsat[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    ud_r <= ud_nxt;
    for (int k = 0; k < 2; k++) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= low_nxt[k];
      q_r[k] <= q_nxt[k];
      neg_r[k] <= neg_nxt[k];
      spec_r[k] <= spec_nxt[k];
      sval_r[k] <= sval_nxt[k];
    end
  end

  assign busy  = busy_r;
  assign quo_a = res[0];
  assign quo_b = res[1];
  assign sat   = |rsat;

endmodule

// ===== hdl/adi_dp.sv =====
// Datapath: grid memories, coefficient registers, shared multiplier, divider, result register.
module adi_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  adi_pkg::dp_cmd_t              cmd,
  output adi_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [adi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [adi_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic [adi_pkg::DATA_W-1:0]    in_temp,
  input  logic                          in_interior,
  output logic [adi_pkg::DATA_W-1:0]    out_temp,
  output logic                          out_interior,
  output logic                          out_sat
);
  import adi_pkg::*;

  logic [DATA_W-1:0] x_off_r, x_diag_r, y_off_r, y_diag_r, tw_r;

  logic [DATA_W-1:0] rd_temp, rd_half, rd_alpha, rd_beta;
  logic              rd_mask;

  logic              temp_we, mask_we, half_we, ab_we;
  logic [DATA_W-1:0] temp_wdata, alpha_w, beta_w;
  logic              mask_wdata;

  logic [DATA_W-1:0] off, diag, rhs;
  logic signed [DATA_W:0]   mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [2*DATA_W:0] mul_p;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [WIDE_W-1:0] floor_w, d_r, n_r, n_sum, bk_sum;
  logic [WIDE_W-DATA_W:0]   bk_hi;
  logic                     bk_ovf;
  logic [DATA_W-1:0]        bk_val;

  logic signed [DATA_W-1:0] alpha_prev_r, beta_prev_r, next_r;
  logic                     sat_r;
  logic [DATA_W-1:0]        res_temp_r, out_temp_r;
  logic                     res_int_r, out_int_r, out_sat_r;

  logic              div_busy, div_sat;
  logic [DATA_W-1:0] quo_a, quo_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r  <= RST_OFFDIAG;
      x_diag_r <= RST_DIAG;
      y_off_r  <= RST_OFFDIAG;
      y_diag_r <= RST_DIAG;
      tw_r     <= RST_TWEIGHT;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_X_OFFDIAG:   x_off_r  <= cfg_wdata;
        CFG_X_DIAG:      x_diag_r <= cfg_wdata;
        CFG_Y_OFFDIAG:   y_off_r  <= cfg_wdata;
        CFG_Y_DIAG:      y_diag_r <= cfg_wdata;
        CFG_TIME_WEIGHT: tw_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // First sweep runs along i with the y coefficients, second along j with x.
  assign off  = cmd.sweep ? x_off_r : y_off_r;
  assign diag = cmd.sweep ? x_diag_r : y_diag_r;
  assign rhs  = cmd.sweep ? rd_half : rd_temp;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      DP_MUL_A: begin
        mul_a = $signed({1'b0, off});
        mul_b = alpha_prev_r;
      end
      DP_MUL_B: begin
        mul_a = $signed({1'b0, off});
        mul_b = beta_prev_r;
      end
      DP_MUL_C: begin
        mul_a = $signed({1'b0, tw_r});
        mul_b = $signed(rhs);
      end
      DP_BK_MUL: begin
        mul_a = $signed({next_r[DATA_W-1], next_r});
        mul_b = $signed(rd_alpha);
      end
      default: ;
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign floor_w = $signed(WIDE_W'(prod_r >>> FRAC_W));
  assign n_sum   = n_r + floor_w;

  // Back substitution: add beta, clamp to 32 bits
  assign bk_sum = floor_w + $signed({{(WIDE_W - DATA_W){rd_beta[DATA_W-1]}}, rd_beta});
  assign bk_hi  = bk_sum[WIDE_W-1:DATA_W-1];
  assign bk_ovf = !((&bk_hi) || !(|bk_hi));
  always_comb begin
    if (!cmd.solved) begin
      bk_val = rd_temp;
    end else if (bk_ovf) begin
      bk_val = bk_sum[WIDE_W-1] ? Q_MIN : Q_MAX;
    end else begin
      bk_val = bk_sum[DATA_W-1:0];
    end
  end

  assign alpha_w = cmd.solved ? quo_a : '0;
  assign beta_w  = cmd.solved ? quo_b : rd_temp;

  always_ff @(posedge clk) begin
    if (cmd.op == DP_MUL_A || cmd.op == DP_MUL_B || cmd.op == DP_MUL_C ||
        cmd.op == DP_BK_MUL) begin
      prod_r <= $signed(mul_p[PROD_W-1:0]);
    end
    if (cmd.op == DP_MUL_B) begin
      d_r <= $signed({{(WIDE_W - DATA_W){1'b0}}, diag}) - floor_w;
    end
    if (cmd.op == DP_MUL_C) begin
      n_r <= floor_w;
    end
    if (cmd.op == DP_FWD_WR) begin
      alpha_prev_r <= $signed(alpha_w);
      beta_prev_r  <= $signed(beta_w);
    end
    if (cmd.op == DP_BK_WR) begin
      next_r <= $signed(bk_val);
    end
  end

  adi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == DP_DIV_GO),
    .num_a ($signed({{(WIDE_W - DATA_W){1'b0}}, off})),
    .num_b (n_sum),
    .den   (d_r),
    .busy  (div_busy),
    .quo_a (quo_a),
    .quo_b (quo_b),
    .sat   (div_sat)
  );

  // Saturation flag: clear at step start, set by any clamped quotient or sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.op == DP_STEP_START) begin
      sat_r <= 1'b0;
    end else if (cmd.op == DP_FWD_WR && cmd.solved && div_sat) begin
      sat_r <= 1'b1;
    end else if (cmd.op == DP_BK_WR && cmd.solved && bk_ovf) begin
      sat_r <= 1'b1;
    end
  end

  // Memory write selection
  assign temp_we = cmd.op == DP_CLEAR || cmd.op == DP_WRCELL ||
                   (cmd.op == DP_BK_WR && cmd.sweep);
  assign mask_we = cmd.op == DP_CLEAR || cmd.op == DP_WRCELL;
  assign half_we = cmd.op == DP_BK_WR && !cmd.sweep;
  assign ab_we   = cmd.op == DP_FWD_WR;

  always_comb begin
    unique case (cmd.op)
      DP_CLEAR:  temp_wdata = '0;
      DP_WRCELL: temp_wdata = in_temp;
      default:   temp_wdata = bk_val;
    endcase
  end
  assign mask_wdata = (cmd.op == DP_WRCELL) ? in_interior : 1'b0;

  adi_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_temp (
    .clk(clk), .we(temp_we), .waddr(cmd.addr), .wdata(temp_wdata),
    .raddr(cmd.addr), .rdata(rd_temp)
  );
  adi_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_half (
    .clk(clk), .we(half_we), .waddr(cmd.addr), .wdata(bk_val),
    .raddr(cmd.addr), .rdata(rd_half)
  );
  adi_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_alpha (
    .clk(clk), .we(ab_we), .waddr(cmd.addr), .wdata(alpha_w),
    .raddr(cmd.addr), .rdata(rd_alpha)
  );
  adi_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_beta (
    .clk(clk), .we(ab_we), .waddr(cmd.addr), .wdata(beta_w),
    .raddr(cmd.addr), .rdata(rd_beta)
  );
  adi_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mask (
    .clk(clk), .we(mask_we), .waddr(cmd.addr), .wdata(mask_wdata),
    .raddr(cmd.addr), .rdata(rd_mask)
  );

  // Result staging and output register
  always_ff @(posedge clk) begin
    if (cmd.op == DP_RDCAP) begin
      res_temp_r <= rd_temp;
      res_int_r  <= rd_mask;
    end else if (cmd.op == DP_WRCELL || cmd.op == DP_RES_ZERO ||
                 cmd.op == DP_STEP_START) begin
      res_temp_r <= '0;
      res_int_r  <= 1'b0;
    end
    if (cmd.out_load) begin
      out_temp_r <= res_temp_r;
      out_int_r  <= res_int_r;
      out_sat_r  <= sat_r;
    end
  end

  assign stat.mask     = rd_mask;
  assign stat.div_busy = div_busy;
  assign out_temp      = out_temp_r;
  assign out_interior  = out_int_r;
  assign out_sat       = out_sat_r;

endmodule

// ===== hdl/adi_ctrl.sv =====
// Controller: clearing pass, command decode and the sweep sequencer.
module adi_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [adi_pkg::MODE_W-1:0] in_mode,
  input  logic [adi_pkg::IDX_W-1:0] in_index_i,
  input  logic [adi_pkg::IDX_W-1:0] in_index_j,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  adi_pkg::dp_stat_t         stat,
  output adi_pkg::dp_cmd_t          cmd
);
  import adi_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_RD    = 14'b00000000000100,
    S_DONE  = 14'b00000000001000,
    S_FRD   = 14'b00000000010000,
    S_FM1   = 14'b00000000100000,
    S_FM2   = 14'b00000001000000,
    S_FM3   = 14'b00000010000000,
    S_FDS   = 14'b00000100000000,
    S_FDIV  = 14'b00001000000000,
    S_FWR   = 14'b00010000000000,
    S_BRD   = 14'b00100000000000,
    S_BM1   = 14'b01000000000000,
    S_BWR   = 14'b10000000000000
  } state_t;

  function automatic logic [CELL_W-1:0] cell_addr(input logic [IW-1:0] i,
                                                  input logic [JW-1:0] j);
    cell_addr = CELL_W'(CELL_W'(i) * CELL_W'(GRID_J)) + CELL_W'(j);
  endfunction

  state_t            state_r, state_nxt;
  logic [CELL_W-1:0] clr_r, clr_nxt;
  logic              sweep_r, sweep_nxt;
  logic [PW-1:0]     line_r, line_nxt, pos_r, pos_nxt;
  logic              solved_r, solved_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [IW-1:0]     ci;
  logic [JW-1:0]     cj;
  logic              on_edge, accept, in_grid, out_free;
  logic [PW-1:0]     len_m1, lines_m1;
  logic [CELL_W-1:0] step_addr, in_addr;
  mode_t             mode;

  assign mode     = mode_t'(in_mode);
  assign accept   = in_tvalid && in_tready;
  assign in_grid  = (int'(in_index_i) < GRID_I) && (int'(in_index_j) < GRID_J);
  assign in_addr  = cell_addr(IW'(in_index_i), JW'(in_index_j));
  assign out_free = !out_valid_r || out_tready;

  assign ci       = sweep_r ? IW'(line_r) : IW'(pos_r);
  assign cj       = sweep_r ? JW'(pos_r) : JW'(line_r);
  assign on_edge  = (ci == '0) || (ci == IW'(GRID_I - 1)) ||
                    (cj == '0) || (cj == JW'(GRID_J - 1));
  assign len_m1   = sweep_r ? PW'(GRID_J - 1) : PW'(GRID_I - 1);
  assign lines_m1 = sweep_r ? PW'(GRID_I - 1) : PW'(GRID_J - 1);
  assign step_addr = cell_addr(ci, cj);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    sweep_nxt  = sweep_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    solved_nxt = solved_r;
    cmd.op       = DP_NOP;
    cmd.addr     = step_addr;
    cmd.sweep    = sweep_r;
    cmd.solved   = solved_r;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op   = DP_CLEAR;
        cmd.addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == CELL_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.addr = in_addr;
        if (accept) begin
          unique case (mode)
            MODE_WRITE: begin
              cmd.op    = in_grid ? DP_WRCELL : DP_RES_ZERO;
              state_nxt = S_DONE;
            end
            MODE_STEP: begin
              cmd.op    = DP_STEP_START;
              sweep_nxt = 1'b0;
              line_nxt  = '0;
              pos_nxt   = '0;
              state_nxt = S_FRD;
            end
            MODE_READ: begin
              cmd.op    = in_grid ? DP_NOP : DP_RES_ZERO;
              state_nxt = in_grid ? S_RD : S_DONE;
            end
            MODE_NONE: begin
              cmd.op    = DP_RES_ZERO;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.op    = DP_RDCAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FRD: state_nxt = S_FM1;
      S_FM1: begin
        cmd.op     = DP_MUL_A;
        solved_nxt = stat.mask && !on_edge;
        state_nxt  = (stat.mask && !on_edge) ? S_FM2 : S_FWR;
      end
      S_FM2: begin
        cmd.op    = DP_MUL_B;
        state_nxt = S_FM3;
      end
      S_FM3: begin
        cmd.op    = DP_MUL_C;
        state_nxt = S_FDS;
      end
      S_FDS: begin
        cmd.op    = DP_DIV_GO;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        cmd.op = DP_FWD_WR;
        if (pos_r == len_m1) begin
          state_nxt = S_BRD;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_BRD: state_nxt = S_BM1;
      S_BM1: begin
        cmd.op     = DP_BK_MUL;
        solved_nxt = stat.mask && !on_edge;
        state_nxt  = S_BWR;
      end
      S_BWR: begin
        cmd.op = DP_BK_WR;
        if (pos_r != '0) begin
          pos_nxt   = pos_r - 1'b1;
          state_nxt = S_BRD;
        end else if (line_r != lines_m1) begin
          line_nxt  = line_r + 1'b1;
          state_nxt = S_FRD;
        end else if (!sweep_r) begin
          sweep_nxt = 1'b1;
          line_nxt  = '0;
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sweep_r     <= 1'b0;
      line_r      <= '0;
      pos_r       <= '0;
      solved_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sweep_r     <= sweep_nxt;
      line_r      <= line_nxt;
      pos_r       <= pos_nxt;
      solved_r    <= solved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/adi_heat_step_core.sv =====
// Top level of the ADI heat step core: stream ports, controller and datapath.
// A cell write goes from acceptance straight to the result state, a read first
// captures the cell. A step walks both sweeps cell by cell; a solved cell waits
// on the radix-2 divider, a boundary cell skips it. One item is in work at a time.
// Reset (rst_n low, synchronous) runs a clearing pass over temperature and
// interior mask; no input beat is taken until it ends, configuration writes are.
module adi_heat_step_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [5:0] index_i, [11:6] index_j, [43:12] temp_in, [44] interior_in, [47:45] zero
  input  logic [adi_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [1:0] mode
  input  logic [adi_pkg::MODE_W-1:0]           in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] temp_out, [32] interior_out, [33] saturated, [39:34] zero
  output logic [adi_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [adi_pkg::DATA_W-1:0]           cfg_data
);
  import adi_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [DATA_W-1:0] out_temp;
  logic              out_interior, out_sat;

  // Always take configuration beats; the user must write only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  adi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .in_index_i (in_tdata[IDX_W-1:0]),
    .in_index_j (in_tdata[2*IDX_W-1:IDX_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  adi_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .in_temp      (in_tdata[2*IDX_W+DATA_W-1:2*IDX_W]),
    .in_interior  (in_tdata[2*IDX_W+DATA_W]),
    .out_temp     (out_temp),
    .out_interior (out_interior),
    .out_sat      (out_sat)
  );

  // Pack the result beat, lowest field first
  assign out_tdata = {{(OUT_TDATA_W - DATA_W - 2){1'b0}}, out_sat, out_interior, out_temp};

endmodule

// ===== hdl/adi_chk.sv =====
// Port-level checker for the ADI heat step core, bound to the top level.
module adi_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [adi_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // After reset no result is pending and the clearing pass blocks input beats.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("result or input ready right after reset");

  // One item at a time: an accepted beat always blocks the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result beat changed");

endmodule

bind adi_heat_step_core adi_chk u_adi_chk (.*);

// ===== tb/adi_heat_step_core_tb.sv =====
// Self-checking testbench for the ADI heat step core: scoreboard class, stream drivers, checks.
`timescale 1ns / 1ps

module adi_heat_step_core_tb;
  import adi_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int PHASE_ITEMS  = 420;

  typedef struct {
    logic [31:0] temp;
    logic        interior;
    logic        sat;
  } heat_result_t;

  // Scoreboard: keeps its own copy of the grid and the coefficients and predicts
  // one result beat per accepted input beat.
  class heat_scoreboard;
    logic signed [31:0] temp_grid [0:CELLS-1];
    logic signed [31:0] half_grid [0:CELLS-1];
    logic signed [31:0] alpha_grid [0:CELLS-1];
    logic signed [31:0] beta_grid [0:CELLS-1];
    logic               mask_grid [0:CELLS-1];
    logic               sat_flag;
    logic [31:0]        coef [0:4];
    heat_result_t       pending [$];

    function new();
      for (int c = 0; c < CELLS; c++) begin
        temp_grid[c] = '0;
        half_grid[c] = '0;
        alpha_grid[c] = '0;
        beta_grid[c] = '0;
        mask_grid[c] = 1'b0;
      end
      sat_flag = 1'b0;
      coef[CFG_X_OFFDIAG] = RST_OFFDIAG;
      coef[CFG_X_DIAG] = RST_DIAG;
      coef[CFG_Y_OFFDIAG] = RST_OFFDIAG;
      coef[CFG_Y_DIAG] = RST_DIAG;
      coef[CFG_TIME_WEIGHT] = RST_TWEIGHT;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx <= CFG_TIME_WEIGHT) coef[idx] = val;
    endfunction

    function longint signed floor16(longint signed v);
      return v >>> 16;
    endfunction

    function logic signed [31:0] clamp32(longint signed v);
      if (v > longint'(32'sh7FFF_FFFF)) begin
        sat_flag = 1'b1;
        return Q_MAX;
      end
      if (v < -longint'(64'h8000_0000)) begin
        sat_flag = 1'b1;
        return Q_MIN;
      end
      return v[31:0];
    endfunction

    // Q16.16 quotient, truncated toward zero, saturating on zero divisor or overflow.
    function logic signed [31:0] qdiv(longint signed n, longint signed d);
      logic [63:0] un, ud, q, negq;
      logic neg;
      if (d == 0) begin
        sat_flag = 1'b1;
        if (n > 0) return Q_MAX;
        if (n < 0) return Q_MIN;
        return '0;
      end
      un = n;
      if (n < 0) un = 64'd0 - un;
      ud = d;
      if (d < 0) ud = 64'd0 - ud;
      q = (un << 16) / ud;
      neg = (n < 0) != (d < 0);
      if (!neg) begin
        if (q > 64'h7FFF_FFFF) begin
          sat_flag = 1'b1;
          return Q_MAX;
        end
        return q[31:0];
      end
      if (q > 64'h8000_0000) begin
        sat_flag = 1'b1;
        return Q_MIN;
      end
      negq = 64'd0 - q;
      return negq[31:0];
    endfunction

    function bit solved(int i, int j);
      if (i <= 0 || i >= GRID_I - 1 || j <= 0 || j >= GRID_J - 1) return 1'b0;
      return mask_grid[i * GRID_J + j];
    endfunction

    // One family of line solves; along_i reads the grid and fills the half step,
    // otherwise it reads the half step and writes back into the grid.
    function void sweep(bit along_i, logic [31:0] off, logic [31:0] diag);
      int lines, len, stride, i, j, c;
      longint signed offl, diagl, twl, d, n, v, rhs, nxt;
      lines = along_i ? GRID_J : GRID_I;
      len = along_i ? GRID_I : GRID_J;
      stride = along_i ? GRID_J : 1;
      offl = longint'({32'd0, off});
      diagl = longint'({32'd0, diag});
      twl = longint'({32'd0, coef[CFG_TIME_WEIGHT]});
      for (int ln = 0; ln < lines; ln++) begin
        for (int p = 0; p < len; p++) begin
          i = along_i ? p : ln;
          j = along_i ? ln : p;
          c = i * GRID_J + j;
          if (!solved(i, j)) begin
            alpha_grid[c] = '0;
            beta_grid[c] = temp_grid[c];
          end else begin
            rhs = along_i ? longint'(temp_grid[c]) : longint'(half_grid[c]);
            d = diagl - floor16(offl * longint'(alpha_grid[c - stride]));
            n = floor16(offl * longint'(beta_grid[c - stride])) + floor16(twl * rhs);
            alpha_grid[c] = qdiv(offl, d);
            beta_grid[c] = qdiv(n, d);
          end
        end
        for (int p = len - 1; p >= 0; p--) begin
          i = along_i ? p : ln;
          j = along_i ? ln : p;
          c = i * GRID_J + j;
          if (!solved(i, j)) begin
            if (along_i) half_grid[c] = temp_grid[c];
          end else begin
            nxt = along_i ? longint'(half_grid[c + stride]) : longint'(temp_grid[c + stride]);
            v = floor16(nxt * longint'(alpha_grid[c])) + longint'(beta_grid[c]);
            if (along_i) half_grid[c] = clamp32(v);
            else temp_grid[c] = clamp32(v);
          end
        end
      end
    endfunction

    function void note_input(mode_t mode, logic [5:0] ii, logic [5:0] jj,
                             logic [31:0] tin, logic interior);
      heat_result_t r;
      int c;
      c = int'(ii) * GRID_J + int'(jj);
      r.temp = '0;
      r.interior = 1'b0;
      case (mode)
        MODE_WRITE: begin
          temp_grid[c] = tin;
          mask_grid[c] = interior;
        end
        MODE_STEP: begin
          sat_flag = 1'b0;
          sweep(1'b1, coef[CFG_Y_OFFDIAG], coef[CFG_Y_DIAG]);
          sweep(1'b0, coef[CFG_X_OFFDIAG], coef[CFG_X_DIAG]);
        end
        MODE_READ: begin
          r.temp = temp_grid[c];
          r.interior = mask_grid[c];
        end
        default: ;
      endcase
      r.sat = sat_flag;
      pending.insert(pending.size(), r);
    endfunction

    function bit check(logic [OUT_TDATA_W-1:0] beat, output string msg);
      heat_result_t e;
      if (pending.size() == 0) begin
        msg = $sformatf("result beat %h with nothing expected", beat);
        return 1'b0;
      end
      e = pending.pop_front();
      if (beat[31:0] !== e.temp || beat[32] !== e.interior || beat[33] !== e.sat
          || beat[39:34] !== 6'd0) begin
        msg = $sformatf("temp %h/%h interior %b/%b saturated %b/%b pad %h (got/exp)",
                        beat[31:0], e.temp, beat[32], e.interior, beat[33], e.sat,
                        beat[39:34]);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]      in_tuser = MODE_NONE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;

  heat_scoreboard grid_sb = new();
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;       // no idling on either side while set
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  adi_heat_step_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung block: the slowest step here is far below this limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("adi_heat_step_core_tb NOT OK");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Check every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      if (!grid_sb.check(out_tdata, msg)) report(msg);
    end
  end

  // Hold valid until the beat is taken, then note it in the scoreboard.
  task automatic send_item(mode_t mode, logic [5:0] ii, logic [5:0] jj,
                           logic [31:0] tin, logic interior);
    while (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {3'b000, interior, tin, jj, ii};
    do @(posedge clk); while (!in_tready);
    grid_sb.note_input(mode, ii, jj, tin, interior);
  endtask

  // Leave valid high; the caller drops it once the last beat is taken.
  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    grid_sb.set_coef(idx, val);
  endtask

  // Drop valid and let every expected beat drain before touching registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (grid_sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_coefs(logic [31:0] xo, logic [31:0] xd, logic [31:0] yo,
                           logic [31:0] yd, logic [31:0] tw);
    write_coef(CFG_X_OFFDIAG, xo);
    write_coef(CFG_X_DIAG, xd);
    write_coef(CFG_Y_OFFDIAG, yo);
    write_coef(CFG_Y_DIAG, yd);
    write_coef(CFG_TIME_WEIGHT, tw);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_temp();
    case ($urandom_range(3))
      0: return $urandom_range(32'h000F_FFFF);
      1: return 32'd0 - $urandom_range(32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Random phase: a small interior patch so sweeps chain through solved cells,
  // then mostly writes and reads, with a rare step and one step at the end.
  task automatic random_phase(int items);
    int oi, oj, r;
    oi = $urandom_range(58);
    oj = $urandom_range(58);
    for (int a = 0; a < 5; a++)
      for (int b = 0; b < 5; b++)
        send_item(MODE_WRITE, 6'(oi + a), 6'(oj + b), rand_temp(), 1'b1);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(999);
      if (r < 470)
        send_item(MODE_WRITE, 6'($urandom), 6'($urandom), rand_temp(),
                  $urandom_range(9) == 0);
      else if (r < 985)
        send_item(MODE_READ, 6'($urandom), 6'($urandom), $urandom, 1'($urandom));
      else if (r < 997)
        send_item(MODE_NONE, 6'($urandom), 6'($urandom), $urandom, 1'($urandom));
      else
        send_item(MODE_STEP, 6'($urandom), 6'($urandom), $urandom, 1'($urandom));
    end
    send_item(MODE_STEP, '0, '0, '0, 1'b0);
    for (int a = 0; a < 5; a++)
      send_item(MODE_READ, 6'(oi + a), 6'(oj + a), '0, 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: grid edges, extremes of temperature, a solved pair, every mode.
    set_coefs(RST_OFFDIAG, RST_DIAG, RST_OFFDIAG, RST_DIAG, RST_TWEIGHT);
    send_item(MODE_READ, 6'd5, 6'd7, '0, 1'b0);
    send_item(MODE_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, 1'b1);
    send_item(MODE_WRITE, 6'd63, 6'd63, 32'h8000_0000, 1'b1);
    send_item(MODE_WRITE, 6'd0, 6'd63, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_WRITE, 6'd63, 6'd0, 32'h0001_0000, 1'b0);
    send_item(MODE_WRITE, 6'd1, 6'd1, 32'h7FFF_FFFF, 1'b1);
    send_item(MODE_WRITE, 6'd1, 6'd2, 32'h8000_0000, 1'b1);
    send_item(MODE_WRITE, 6'd2, 6'd1, 32'h0005_8000, 1'b1);
    send_item(MODE_WRITE, 6'd62, 6'd62, 32'hFFF0_0000, 1'b1);
    send_item(MODE_WRITE, 6'd31, 6'd31, 32'h0010_0000, 1'b0);
    send_item(MODE_NONE, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_READ, 6'd0, 6'd0, '0, 1'b0);
    send_item(MODE_READ, 6'd63, 6'd63, '0, 1'b0);
    send_item(MODE_READ, 6'd1, 6'd1, '0, 1'b0);
    send_item(MODE_STEP, '0, '0, '0, 1'b0);
    send_item(MODE_READ, 6'd1, 6'd1, '0, 1'b0);
    send_item(MODE_READ, 6'd1, 6'd2, '0, 1'b0);
    send_item(MODE_READ, 6'd2, 6'd1, '0, 1'b0);
    send_item(MODE_READ, 6'd62, 6'd62, '0, 1'b0);
    send_item(MODE_READ, 6'd0, 6'd63, '0, 1'b0);
    send_item(MODE_NONE, '0, '0, '0, 1'b0);

    // Default coefficients; a calm stretch and the long receiver hold-off.
    calm = 1'b1;
    random_phase(150);
    calm = 1'b0;
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS - 150);
    drain();

    // Largest coefficients with zero diagonal: divisions by zero and overflow.
    set_coefs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);
    drain();

    // All zero: zero over zero and a vanishing right-hand side.
    set_coefs('0, '0, '0, '0, '0);
    random_phase(PHASE_ITEMS);
    drain();

    // Random but well-conditioned coefficients.
    set_coefs($urandom_range(32'h0003_0000), $urandom_range(32'h0008_0000, 32'h0002_0000),
              $urandom_range(32'h0003_0000), $urandom_range(32'h0008_0000, 32'h0002_0000),
              $urandom);
    random_phase(PHASE_ITEMS);
    drain();

    if (fail_count == 0 && grid_sb.pending.size() == 0) begin
      $display("adi_heat_step_core_tb OK");
    end else begin
      $display("adi_heat_step_core_tb NOT OK");
    end
    $finish;
  end

endmodule
